@@ rtl/bdfc_pkg.sv @@
// shared widths, codes and constant-step coefficient table of the bdf coefficient block
package bdfc_pkg;

	localparam int STEP_BITS     = 24;
	localparam int FRACTION_BITS = 24;
	localparam int ORDER_BITS    = 3;
	localparam int GAMMA_BITS    = FRACTION_BITS + 2;
	localparam int ALPHA_BITS    = FRACTION_BITS + 16;

	// datapath widths: factor, first product, split operand, full product
	localparam int FACT_BITS = STEP_BITS + 2;
	localparam int MUL1_BITS = 2 * FACT_BITS;
	localparam int HALF_BITS = FACT_BITS + 1;
	localparam int OPND_BITS = 2 * HALF_BITS;
	localparam int PROD_BITS = 4 * HALF_BITS;

	// divider: rounded quotient needs one guard bit above the alpha field
	localparam int QUOT_BITS = ALPHA_BITS + 1;
	localparam int REM_BITS  = PROD_BITS + QUOT_BITS + 1;

	localparam int NUM_COEF = 5;
	localparam int NUM_PROD = 9;

	// configuration port
	localparam int REG_SHIFT = 2;
	localparam int ADDR_BITS = REG_SHIFT + 1;
	localparam int DATA_BITS = 32;

	localparam logic [ORDER_BITS-1:0] MAX_ORDER           = ORDER_BITS'(4);
	localparam logic [ORDER_BITS-1:0] HIGHEST_ORDER_RESET = ORDER_BITS'(4);

	// saturation limits on the rounded magnitude
	localparam logic [QUOT_BITS-1:0] GAMMA_LIM =
		{{(QUOT_BITS - GAMMA_BITS){1'b0}}, {GAMMA_BITS{1'b1}}};
	localparam logic [QUOT_BITS-1:0] ALPHA_POS_LIM = {2'b00, {(ALPHA_BITS - 1){1'b1}}};
	localparam logic [QUOT_BITS-1:0] ALPHA_NEG_LIM = {2'b01, {(ALPHA_BITS - 1){1'b0}}};

	typedef enum logic [0:0] {
		REG_HIGHEST_ORDER = 1'b0,
		REG_ADAPTIVE_MODE = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_STEP = 2'd1,
		ST_BAD_ORDER = 2'd2,
		ST_SATURATED = 2'd3
	} status_t;

	typedef struct packed {
		logic       neg;
		logic [4:0] num;
		logic [3:0] den;
	} tab_entry_t;

	// constant-step coefficients: index 0 gamma0, 1..4 alpha0..alpha3
	function automatic tab_entry_t const_coef(input logic [1:0] ord_m1, input logic [2:0] k);
		tab_entry_t e;
		e = '{neg: 1'b0, num: 5'd0, den: 4'd1};
		unique case ({ord_m1, k})
			5'b00_000: e = '{1'b0, 5'd1, 4'd1};
			5'b00_001: e = '{1'b0, 5'd1, 4'd1};
			5'b01_000: e = '{1'b0, 5'd3, 4'd2};
			5'b01_001: e = '{1'b0, 5'd2, 4'd1};
			5'b01_010: e = '{1'b1, 5'd1, 4'd2};
			5'b10_000: e = '{1'b0, 5'd11, 4'd6};
			5'b10_001: e = '{1'b0, 5'd3, 4'd1};
			5'b10_010: e = '{1'b1, 5'd3, 4'd2};
			5'b10_011: e = '{1'b0, 5'd1, 4'd3};
			5'b11_000: e = '{1'b0, 5'd25, 4'd12};
			5'b11_001: e = '{1'b0, 5'd4, 4'd1};
			5'b11_010: e = '{1'b1, 5'd3, 4'd1};
			5'b11_011: e = '{1'b0, 5'd4, 4'd3};
			5'b11_100: e = '{1'b1, 5'd1, 4'd4};
			default: ;
		endcase
		return e;
	endfunction

endpackage

@@ rtl/bdfc_in_if.sv @@
// input channel: requested order and four step sizes
interface bdfc_in_if;
	logic                               valid;
	logic                               ready;
	logic [bdfc_pkg::ORDER_BITS-1:0]    req_order;
	logic [bdfc_pkg::STEP_BITS-1:0]     step_newest;
	logic [bdfc_pkg::STEP_BITS-1:0]     step_second;
	logic [bdfc_pkg::STEP_BITS-1:0]     step_third;
	logic [bdfc_pkg::STEP_BITS-1:0]     step_fourth;

	modport source (
		output valid, req_order, step_newest, step_second, step_third, step_fourth,
		input  ready
	);
	modport sink (
		input  valid, req_order, step_newest, step_second, step_third, step_fourth,
		output ready
	);
endinterface

@@ rtl/bdfc_out_if.sv @@
// output channel: gamma0, four alphas and status
interface bdfc_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [bdfc_pkg::GAMMA_BITS-1:0]        gamma_zero;
	logic signed [bdfc_pkg::ALPHA_BITS-1:0] alpha_one;
	logic signed [bdfc_pkg::ALPHA_BITS-1:0] alpha_two;
	logic signed [bdfc_pkg::ALPHA_BITS-1:0] alpha_three;
	logic signed [bdfc_pkg::ALPHA_BITS-1:0] alpha_four;
	logic [1:0]                             status;

	modport source (
		output valid, gamma_zero, alpha_one, alpha_two, alpha_three, alpha_four, status,
		input  ready
	);
	modport sink (
		input  valid, gamma_zero, alpha_one, alpha_two, alpha_three, alpha_four, status,
		output ready
	);
endinterface

@@ rtl/bdf_variable_step_coefficients_core.sv @@
// Variable-step BDF coefficient pipeline (orders 1 to 4) with APB configuration.
// Takes one item per clock while the output is not stalled. Six stages form the
// rational numerators and denominators (step sums, 26x26 multiplies, split 54x54
// partial products, summation, selection); five parallel restoring dividers then
// produce one quotient bit per stage, and that bit-per-stage divider sets the
// latency. The whole pipeline advances whenever the output register is empty or
// being taken, so a stall loses and repeats nothing. Coefficients are exact
// rationals rounded to nearest, ties away from zero; an invalid order reports
// status 2, a zero step in adaptive mode status 1, a clamped coefficient status 3,
// with zero coefficients in the first two cases. No clearing pass runs after reset.
module bdf_variable_step_coefficients_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bdfc_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [bdfc_pkg::DATA_BITS-1:0]      pwdata,
	output logic [bdfc_pkg::DATA_BITS-1:0]      prdata,
	output logic                                pready,
	bdfc_in_if.sink                             item,
	bdfc_out_if.source                          result
);

	localparam int L  = bdfc_pkg::FACT_BITS;
	localparam int H  = bdfc_pkg::HALF_BITS;
	localparam int QB = bdfc_pkg::QUOT_BITS;
	localparam int NC = bdfc_pkg::NUM_COEF;
	localparam int NP = bdfc_pkg::NUM_PROD;

	// product lanes
	localparam int P_BASE = 0;
	localparam int P_AE   = 1;
	localparam int P_DEN1 = 2;
	localparam int P_NUM2 = 3;
	localparam int P_DEN2 = 4;
	localparam int P_NUM3 = 5;
	localparam int P_DEN3 = 6;
	localparam int P_NUM4 = 7;
	localparam int P_DEN4 = 8;

	localparam logic [L-1:0] ONE_F  = L'(1);
	localparam logic [L-1:0] ZERO_F = '0;

	typedef struct packed {
		logic       bad_order;
		logic       zero_step;
		logic       use_table;
		logic       ge3;
		logic       eq4;
		logic [1:0] ord_m1;
	} ctl_t;

	// configuration registers
	logic [bdfc_pkg::ORDER_BITS-1:0] highest_order_q;
	logic                            adaptive_mode_q;
	logic                            cfg_wr;
	bdfc_pkg::reg_index_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = bdfc_pkg::reg_index_t'(paddr[bdfc_pkg::ADDR_BITS-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_order_q <= bdfc_pkg::HIGHEST_ORDER_RESET;
			adaptive_mode_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				bdfc_pkg::REG_HIGHEST_ORDER: highest_order_q <= pwdata[bdfc_pkg::ORDER_BITS-1:0];
				bdfc_pkg::REG_ADAPTIVE_MODE: adaptive_mode_q <= pwdata[0];
			endcase
		end
	end

	// register read
	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			bdfc_pkg::REG_HIGHEST_ORDER: prdata[bdfc_pkg::ORDER_BITS-1:0] = highest_order_q;
			bdfc_pkg::REG_ADAPTIVE_MODE: prdata[0] = adaptive_mode_q;
		endcase
	end

	// pipeline advance: everything moves unless the output holds an untaken transfer
	logic adv;
	logic res_valid_q;

	assign adv        = !res_valid_q || result.ready;
	assign item.ready = adv;

	// stage 1: captured item
	logic                             v_s1;
	logic [bdfc_pkg::ORDER_BITS-1:0]  ord_s1;
	logic [bdfc_pkg::ORDER_BITS-1:0]  hi_ord_s1;
	logic                             adapt_s1;
	logic [bdfc_pkg::STEP_BITS-1:0]   sa_s1, sb_s1, sc_s1, sd_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ord_s1    <= item.req_order;
			hi_ord_s1 <= highest_order_q;
			adapt_s1  <= adaptive_mode_q;
			sa_s1     <= item.step_newest;
			sb_s1     <= item.step_second;
			sc_s1     <= item.step_third;
			sd_s1     <= item.step_fourth;
		end
	end

	// stage 1 logic: step sums, order decode, factor selection, first multiplies
	logic [L-1:0] fa, fb, fc, fd, s2, s3, s4, u2, u3, v2, fy, fz;
	logic [bdfc_pkg::ORDER_BITS-1:0] ord_dec;
	ctl_t ctl_c1;
	logic [L-1:0] fct [NP][4];
	logic [bdfc_pkg::MUL1_BITS-1:0] m12_c [NP];
	logic [bdfc_pkg::MUL1_BITS-1:0] m34_c [NP];
	logic [bdfc_pkg::MUL1_BITS-1:0] xy_c, xz_c, yz_c;

	always_comb begin
		fa = L'(sa_s1);
		fb = L'(sb_s1);
		fc = L'(sc_s1);
		fd = L'(sd_s1);
		s2 = fa + fb;
		s3 = s2 + fc;
		s4 = s3 + fd;
		u2 = fb + fc;
		u3 = u2 + fd;
		v2 = fc + fd;
		ord_dec = ord_s1 - bdfc_pkg::ORDER_BITS'(1);
		ctl_c1.ge3       = ord_s1 >= bdfc_pkg::ORDER_BITS'(3);
		ctl_c1.eq4       = ord_s1 == bdfc_pkg::MAX_ORDER;
		ctl_c1.ord_m1    = ord_dec[1:0];
		ctl_c1.bad_order = (ord_s1 == '0) || (ord_s1 > bdfc_pkg::MAX_ORDER) ||
			(ord_s1 > hi_ord_s1);
		ctl_c1.use_table = !adapt_s1 || (ord_s1 == bdfc_pkg::ORDER_BITS'(1));
		ctl_c1.zero_step = !ctl_c1.use_table && ((sa_s1 == '0) || (sb_s1 == '0) ||
			(ctl_c1.ge3 && (sc_s1 == '0)) || (ctl_c1.eq4 && (sd_s1 == '0)));
		fy = ctl_c1.ge3 ? s3 : ONE_F;
		fz = ctl_c1.eq4 ? s4 : ONE_F;

		fct[P_BASE] = '{s2, fy, fz, ONE_F};
		fct[P_AE]   = '{fa, ONE_F, ZERO_F, ZERO_F};
		fct[P_DEN1] = '{fb, ctl_c1.ge3 ? u2 : ONE_F, ctl_c1.eq4 ? u3 : ONE_F, ONE_F};
		fct[P_NUM2] = '{fa, fa, fy, fz};
		fct[P_DEN2] = '{s2, fb, ctl_c1.ge3 ? fc : ONE_F, ctl_c1.eq4 ? v2 : ONE_F};
		fct[P_NUM3] = '{ctl_c1.ge3 ? fa : ZERO_F, fa, s2, fz};
		fct[P_DEN3] = '{ctl_c1.ge3 ? s3 : ONE_F, ctl_c1.ge3 ? u2 : ONE_F,
			ctl_c1.ge3 ? fc : ONE_F, ctl_c1.eq4 ? fd : ONE_F};
		fct[P_NUM4] = '{ctl_c1.eq4 ? fa : ZERO_F, fa, s2, s3};
		fct[P_DEN4] = '{ctl_c1.eq4 ? s4 : ONE_F, ctl_c1.eq4 ? u3 : ONE_F,
			ctl_c1.eq4 ? v2 : ONE_F, ctl_c1.eq4 ? fd : ONE_F};

		for (int p = 0; p < NP; p++) begin
			m12_c[p] = fct[p][0] * fct[p][1];
			m34_c[p] = fct[p][2] * fct[p][3];
		end
		xy_c = s2 * fy;
		xz_c = s2 * fz;
		yz_c = fy * fz;
	end

	// stage 2: first products
	logic v_s2;
	ctl_t ctl_s2;
	logic [bdfc_pkg::MUL1_BITS-1:0] m12_s2 [NP];
	logic [bdfc_pkg::MUL1_BITS-1:0] m34_s2 [NP];
	logic [bdfc_pkg::MUL1_BITS-1:0] xy_s2, xz_s2, yz_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_c1;
			m12_s2 <= m12_c;
			m34_s2 <= m34_c;
			xy_s2  <= xy_c;
			xz_s2  <= xz_c;
			yz_s2  <= yz_c;
		end
	end

	// stage 2 logic: gamma numerator sum term, widen operands
	logic [bdfc_pkg::OPND_BITS-1:0] opa_c [NP];
	logic [bdfc_pkg::OPND_BITS-1:0] opb_c [NP];

	always_comb begin
		for (int p = 0; p < NP; p++) begin
			opa_c[p] = bdfc_pkg::OPND_BITS'(m12_s2[p]);
			opb_c[p] = bdfc_pkg::OPND_BITS'(m34_s2[p]);
		end
		if (ctl_s2.ge3) begin
			opb_c[P_AE] = (ctl_s2.eq4 ? bdfc_pkg::OPND_BITS'(xy_s2) : '0) +
				bdfc_pkg::OPND_BITS'(xz_s2) + bdfc_pkg::OPND_BITS'(yz_s2);
		end else begin
			opb_c[P_AE] = bdfc_pkg::OPND_BITS'(1);
		end
	end

	// stage 3: wide operands
	logic v_s3;
	ctl_t ctl_s3;
	logic [bdfc_pkg::OPND_BITS-1:0] opa_s3 [NP];
	logic [bdfc_pkg::OPND_BITS-1:0] opb_s3 [NP];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3 <= ctl_s2;
			opa_s3 <= opa_c;
			opb_s3 <= opb_c;
		end
	end

	// stage 3 logic: four half-width partial products per lane
	logic [2*H-1:0] pp_c [NP][4];

	always_comb begin
		for (int p = 0; p < NP; p++) begin
			pp_c[p][0] = opa_s3[p][H-1:0]   * opb_s3[p][H-1:0];
			pp_c[p][1] = opa_s3[p][H-1:0]   * opb_s3[p][2*H-1:H];
			pp_c[p][2] = opa_s3[p][2*H-1:H] * opb_s3[p][H-1:0];
			pp_c[p][3] = opa_s3[p][2*H-1:H] * opb_s3[p][2*H-1:H];
		end
	end

	// stage 4: partial products
	logic v_s4;
	ctl_t ctl_s4;
	logic [2*H-1:0] pp_s4 [NP][4];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_s3;
			pp_s4  <= pp_c;
		end
	end

	// stage 4 logic: recombine partial products
	logic [bdfc_pkg::PROD_BITS-1:0] prod_c [NP];

	always_comb begin
		for (int p = 0; p < NP; p++) begin
			prod_c[p] = bdfc_pkg::PROD_BITS'(pp_s4[p][0]) +
				(bdfc_pkg::PROD_BITS'(pp_s4[p][1]) << H) +
				(bdfc_pkg::PROD_BITS'(pp_s4[p][2]) << H) +
				(bdfc_pkg::PROD_BITS'(pp_s4[p][3]) << (2 * H));
		end
	end

	// stage 5: full products
	logic v_s5;
	ctl_t ctl_s5;
	logic [bdfc_pkg::PROD_BITS-1:0] prod_s5 [NP];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5  <= ctl_s4;
			prod_s5 <= prod_c;
		end
	end

	// stage 5 logic: pick variable-step ratios or table constants, blank on errors
	logic [bdfc_pkg::PROD_BITS-1:0] num_c [NC];
	logic [bdfc_pkg::PROD_BITS-1:0] den_c [NC];
	logic                           neg_c [NC];
	bdfc_pkg::tab_entry_t           tab_e [NC];

	always_comb begin
		for (int k = 0; k < NC; k++) begin
			tab_e[k] = bdfc_pkg::const_coef(ctl_s5.ord_m1, 3'(k));
		end
		if (ctl_s5.use_table) begin
			for (int k = 0; k < NC; k++) begin
				num_c[k] = bdfc_pkg::PROD_BITS'(tab_e[k].num);
				den_c[k] = bdfc_pkg::PROD_BITS'(tab_e[k].den);
				neg_c[k] = tab_e[k].neg;
			end
		end else begin
			num_c[0] = prod_s5[P_BASE] + prod_s5[P_AE];
			den_c[0] = prod_s5[P_BASE];
			neg_c[0] = 1'b0;
			num_c[1] = prod_s5[P_BASE];
			den_c[1] = prod_s5[P_DEN1];
			neg_c[1] = 1'b0;
			num_c[2] = prod_s5[P_NUM2];
			den_c[2] = prod_s5[P_DEN2];
			neg_c[2] = 1'b1;
			num_c[3] = prod_s5[P_NUM3];
			den_c[3] = prod_s5[P_DEN3];
			neg_c[3] = 1'b0;
			num_c[4] = prod_s5[P_NUM4];
			den_c[4] = prod_s5[P_DEN4];
			neg_c[4] = 1'b1;
		end
		if (ctl_s5.bad_order || ctl_s5.zero_step) begin
			for (int k = 0; k < NC; k++) begin
				num_c[k] = '0;
				den_c[k] = bdfc_pkg::PROD_BITS'(1);
				neg_c[k] = 1'b0;
			end
		end
	end

	// stage 6: ratios ready for division
	logic v_s6;
	ctl_t ctl_s6;
	logic [bdfc_pkg::PROD_BITS-1:0] num_s6 [NC];
	logic [bdfc_pkg::PROD_BITS-1:0] den_s6 [NC];
	logic                           neg_s6 [NC];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s6 <= ctl_s5;
			num_s6 <= num_c;
			den_s6 <= den_c;
			neg_s6 <= neg_c;
		end
	end

	// divider stages 7 onward, index 0 is the overflow check, index j yields quotient bit QB-j
	logic                            div_v_s7   [QB+1];
	ctl_t                            div_ctl_s7 [QB+1];
	logic [bdfc_pkg::REM_BITS-1:0]   div_rem_s7 [QB+1][NC];
	logic [bdfc_pkg::PROD_BITS-1:0]  div_den_s7 [QB+1][NC];
	logic [QB-1:0]                   div_quo_s7 [QB+1][NC];
	logic                            div_ovf_s7 [QB+1][NC];
	logic                            div_neg_s7 [QB+1][NC];

	logic [bdfc_pkg::REM_BITS-1:0]   rem_init [NC];
	logic [bdfc_pkg::REM_BITS-1:0]   div_sub  [QB+1][NC];
	logic                            div_ge   [QB+1][NC];

	// trial subtract of the shifted divisor, one bit per stage
	always_comb begin
		for (int k = 0; k < NC; k++) begin
			rem_init[k]   = bdfc_pkg::REM_BITS'(num_s6[k]) << (bdfc_pkg::FRACTION_BITS + 1);
			div_sub[0][k] = bdfc_pkg::REM_BITS'(den_s6[k]) << QB;
			div_ge[0][k]  = rem_init[k] >= div_sub[0][k];
		end
		for (int j = 1; j <= QB; j++) begin
			for (int k = 0; k < NC; k++) begin
				div_sub[j][k] = bdfc_pkg::REM_BITS'(div_den_s7[j-1][k]) << (QB - j);
				div_ge[j][k]  = div_rem_s7[j-1][k] >= div_sub[j][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_ctl_s7[0] <= ctl_s6;
			for (int k = 0; k < NC; k++) begin
				div_rem_s7[0][k] <= rem_init[k];
				div_den_s7[0][k] <= den_s6[k];
				div_quo_s7[0][k] <= '0;
				div_ovf_s7[0][k] <= div_ge[0][k];
				div_neg_s7[0][k] <= neg_s6[k];
			end
			for (int j = 1; j <= QB; j++) begin
				div_ctl_s7[j] <= div_ctl_s7[j-1];
				for (int k = 0; k < NC; k++) begin
					div_rem_s7[j][k] <= div_ge[j][k] ?
						div_rem_s7[j-1][k] - div_sub[j][k] : div_rem_s7[j-1][k];
					div_den_s7[j][k] <= div_den_s7[j-1][k];
					div_quo_s7[j][k] <= {div_quo_s7[j-1][k][QB-2:0], div_ge[j][k]};
					div_ovf_s7[j][k] <= div_ovf_s7[j-1][k];
					div_neg_s7[j][k] <= div_neg_s7[j-1][k];
				end
			end
		end
	end

	// rounding, saturation and status
	logic [QB:0]     rnd_c [NC];
	logic [QB-1:0]   mag_c [NC];
	logic [QB-1:0]   lim_c [NC];
	logic [QB-1:0]   val_c [NC];
	logic            sat_c [NC];
	logic            any_sat;
	bdfc_pkg::status_t status_c;

	always_comb begin
		any_sat = 1'b0;
		for (int k = 0; k < NC; k++) begin
			rnd_c[k] = {1'b0, div_quo_s7[QB][k]} + (QB+1)'(1);
			if (k == 0) begin
				lim_c[k] = bdfc_pkg::GAMMA_LIM;
			end else begin
				lim_c[k] = div_neg_s7[QB][k] ? bdfc_pkg::ALPHA_NEG_LIM : bdfc_pkg::ALPHA_POS_LIM;
			end
			sat_c[k] = div_ovf_s7[QB][k] || (rnd_c[k][QB:1] > lim_c[k]);
			mag_c[k] = sat_c[k] ? lim_c[k] : rnd_c[k][QB:1];
			val_c[k] = div_neg_s7[QB][k] ? (QB'(0) - mag_c[k]) : mag_c[k];
			any_sat  = any_sat | sat_c[k];
		end
		priority if (div_ctl_s7[QB].bad_order) begin
			status_c = bdfc_pkg::ST_BAD_ORDER;
		end else if (div_ctl_s7[QB].zero_step) begin
			status_c = bdfc_pkg::ST_ZERO_STEP;
		end else if (any_sat) begin
			status_c = bdfc_pkg::ST_SATURATED;
		end else begin
			status_c = bdfc_pkg::ST_OK;
		end
	end

	// output register
	logic [bdfc_pkg::GAMMA_BITS-1:0]        res_gamma_q;
	logic signed [bdfc_pkg::ALPHA_BITS-1:0] res_alpha_q [4];
	bdfc_pkg::status_t                      res_status_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_gamma_q  <= mag_c[0][bdfc_pkg::GAMMA_BITS-1:0];
			for (int k = 1; k < NC; k++) begin
				res_alpha_q[k-1] <= val_c[k][bdfc_pkg::ALPHA_BITS-1:0];
			end
			res_status_q <= status_c;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			for (int j = 0; j <= QB; j++) begin
				div_v_s7[j] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= item.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			div_v_s7[0] <= v_s6;
			for (int j = 1; j <= QB; j++) begin
				div_v_s7[j] <= div_v_s7[j-1];
			end
			res_valid_q <= div_v_s7[QB];
		end
	end

	assign result.valid       = res_valid_q;
	assign result.gamma_zero  = res_gamma_q;
	assign result.alpha_one   = res_alpha_q[0];
	assign result.alpha_two   = res_alpha_q[1];
	assign result.alpha_three = res_alpha_q[2];
	assign result.alpha_four  = res_alpha_q[3];
	assign result.status      = res_status_q;

`ifndef SYNTHESIS
	// error codes come with all coefficients zero
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_status_q == bdfc_pkg::ST_BAD_ORDER ||
			res_status_q == bdfc_pkg::ST_ZERO_STEP) |->
			res_gamma_q == '0 && res_alpha_q[0] == '0 && res_alpha_q[1] == '0 &&
			res_alpha_q[2] == '0 && res_alpha_q[3] == '0)
		else $error("error status with nonzero coefficients");

	// a clean result always has gamma0 of at least one
	a_gamma_floor: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_status_q == bdfc_pkg::ST_OK |->
			res_gamma_q[bdfc_pkg::GAMMA_BITS-1:bdfc_pkg::FRACTION_BITS] != '0)
		else $error("gamma0 below one on a clean result");

	// saturation shows up as a coefficient at a field limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_status_q == bdfc_pkg::ST_SATURATED |->
			res_gamma_q == {bdfc_pkg::GAMMA_BITS{1'b1}} ||
			res_alpha_q[0] == bdfc_pkg::ALPHA_POS_LIM[bdfc_pkg::ALPHA_BITS-1:0] ||
			res_alpha_q[0] == bdfc_pkg::ALPHA_NEG_LIM[bdfc_pkg::ALPHA_BITS-1:0] ||
			res_alpha_q[1] == bdfc_pkg::ALPHA_POS_LIM[bdfc_pkg::ALPHA_BITS-1:0] ||
			res_alpha_q[1] == bdfc_pkg::ALPHA_NEG_LIM[bdfc_pkg::ALPHA_BITS-1:0] ||
			res_alpha_q[2] == bdfc_pkg::ALPHA_POS_LIM[bdfc_pkg::ALPHA_BITS-1:0] ||
			res_alpha_q[2] == bdfc_pkg::ALPHA_NEG_LIM[bdfc_pkg::ALPHA_BITS-1:0] ||
			res_alpha_q[3] == bdfc_pkg::ALPHA_POS_LIM[bdfc_pkg::ALPHA_BITS-1:0] ||
			res_alpha_q[3] == bdfc_pkg::ALPHA_NEG_LIM[bdfc_pkg::ALPHA_BITS-1:0])
		else $error("saturated status without a clamped coefficient");

	// a stall freezes the occupancy of the pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s6) && $stable(div_v_s7[QB]) && res_valid_q)
		else $error("pipeline moved during a stall");
`endif

endmodule

@@ tb/bdf_variable_step_coefficients_core_tb.sv @@
// self-checking testbench of the bdf coefficient pipeline with exact rational prediction
module bdf_variable_step_coefficients_core_tb;
	import bdfc_pkg::*;

	typedef logic [255:0] wide_t;

	typedef struct {
		logic [ORDER_BITS-1:0] order;
		logic [STEP_BITS-1:0]  step [4];
	} step_item_t;

	typedef struct {
		logic [GAMMA_BITS-1:0] gamma;
		logic [ALPHA_BITS-1:0] alpha [4];
		status_t               status;
	} coef_set_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 80;

	// constant-step coefficients: index 0 gamma0, 1..4 alpha0..alpha3
	int tab_num [4][5] = '{'{1, 1, 0, 0, 0}, '{3, 2, -1, 0, 0},
		'{11, 3, -3, 1, 0}, '{25, 4, -3, 4, -1}};
	int tab_den [4][5] = '{'{1, 1, 1, 1, 1}, '{2, 1, 2, 1, 1},
		'{6, 1, 2, 3, 1}, '{12, 1, 1, 3, 4}};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]  pwdata;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	bdfc_in_if  in_ch ();
	bdfc_out_if out_ch ();

	bdf_variable_step_coefficients_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (in_ch),
		.result  (out_ch)
	);

	// shadow configuration
	logic [2:0] cfg_highest_order;
	logic       cfg_adaptive;

	step_item_t pending_items [$];
	coef_set_t  expected_coefs [$];
	int         idle_mode;
	bit         in_took;
	int         mismatches;
	int         quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// round num/den to nearest, ties away, then clamp
	function automatic logic [63:0] round_ratio(wide_t num, wide_t den, bit neg,
		logic [63:0] pos_lim, logic [63:0] neg_lim, inout bit sat);
		wide_t n, q, r;
		logic [63:0] lim;
		n = num << FRACTION_BITS;
		q = n / den;
		r = n % den;
		if ((r << 1) >= den)
			q = q + 1;
		lim = neg ? neg_lim : pos_lim;
		if (q > wide_t'(lim)) begin
			q = wide_t'(lim);
			sat = 1'b1;
		end
		return neg ? (64'd0 - q[63:0]) : q[63:0];
	endfunction

	function automatic coef_set_t predict_coefs(step_item_t it);
		coef_set_t res;
		wide_t num [5];
		wide_t den [5];
		bit neg [5];
		bit sat;
		int ord;
		wide_t a, b, c, d, s2, s3, s4, u2, u3, v2;
		logic [63:0] v;
		res.gamma = '0;
		for (int k = 0; k < 4; k++)
			res.alpha[k] = '0;
		res.status = ST_OK;
		sat = 1'b0;
		ord = int'(it.order);
		if (ord < 1 || ord > 4 || ord > int'(cfg_highest_order)) begin
			res.status = ST_BAD_ORDER;
			return res;
		end
		for (int k = 0; k < 5; k++) begin
			num[k] = '0;
			den[k] = 1;
			neg[k] = 1'b0;
		end
		a = wide_t'(it.step[0]);
		b = wide_t'(it.step[1]);
		c = wide_t'(it.step[2]);
		d = wide_t'(it.step[3]);
		if (!cfg_adaptive || ord == 1) begin
			for (int k = 0; k <= ord; k++) begin
				neg[k] = tab_num[ord-1][k] < 0;
				num[k] = wide_t'(neg[k] ? -tab_num[ord-1][k] : tab_num[ord-1][k]);
				den[k] = wide_t'(tab_den[ord-1][k]);
			end
		end else begin
			if (a == 0 || b == 0 || (ord >= 3 && c == 0) || (ord == 4 && d == 0)) begin
				res.status = ST_ZERO_STEP;
				return res;
			end
			s2 = a + b; s3 = s2 + c; s4 = s3 + d;
			u2 = b + c; u3 = u2 + d; v2 = c + d;
			if (ord == 2) begin
				num[0] = 2 * a + b; den[0] = s2;
				num[1] = s2;        den[1] = b;
				num[2] = a * a;     den[2] = s2 * b; neg[2] = 1'b1;
			end else if (ord == 3) begin
				num[0] = s2 * s3 + a * (s2 + s3); den[0] = s2 * s3;
				num[1] = s2 * s3;     den[1] = b * u2;
				num[2] = a * a * s3;  den[2] = s2 * b * c;  neg[2] = 1'b1;
				num[3] = a * a * s2;  den[3] = s3 * u2 * c;
			end else begin
				num[0] = s2 * s3 * s4 + a * s3 * s4 + a * s2 * s4 + a * s2 * s3;
				den[0] = s2 * s3 * s4;
				num[1] = s2 * s3 * s4;     den[1] = b * u2 * u3;
				num[2] = a * a * s3 * s4;  den[2] = s2 * b * c * v2;  neg[2] = 1'b1;
				num[3] = a * a * s2 * s4;  den[3] = s3 * u2 * c * d;
				num[4] = a * a * s2 * s3;  den[4] = s4 * u3 * v2 * d; neg[4] = 1'b1;
			end
		end
		v = round_ratio(num[0], den[0], 1'b0, (64'd1 << GAMMA_BITS) - 1, 64'd0, sat);
		res.gamma = v[GAMMA_BITS-1:0];
		for (int k = 1; k <= ord; k++) begin
			v = round_ratio(num[k], den[k], neg[k], (64'd1 << (ALPHA_BITS - 1)) - 1,
				64'd1 << (ALPHA_BITS - 1), sat);
			res.alpha[k-1] = v[ALPHA_BITS-1:0];
		end
		res.status = sat ? ST_SATURATED : ST_OK;
		return res;
	endfunction

	function automatic logic [STEP_BITS-1:0] pick_step();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return STEP_BITS'($urandom_range(1, 4000));
		else if (r < 85)
			return STEP_BITS'($urandom());
		else if (r < 97)
			return ($urandom_range(1)) ? {STEP_BITS{1'b1}} : STEP_BITS'(1);
		return '0;
	endfunction

	function automatic step_item_t random_item();
		step_item_t it;
		it.order = ($urandom_range(99) < 85) ? ORDER_BITS'($urandom_range(1, 4))
			: ORDER_BITS'($urandom_range(7));
		for (int k = 0; k < 4; k++)
			it.step[k] = pick_step();
		return it;
	endfunction

	function automatic step_item_t make_item(int ord, int s0, int s1, int s2, int s3);
		step_item_t it;
		it.order = ORDER_BITS'(ord);
		it.step[0] = STEP_BITS'(s0);
		it.step[1] = STEP_BITS'(s1);
		it.step[2] = STEP_BITS'(s2);
		it.step[3] = STEP_BITS'(s3);
		return it;
	endfunction

	task automatic reg_write(reg_index_t idx, logic [DATA_BITS-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_BITS'(idx) << REG_SHIFT;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_HIGHEST_ORDER)
			cfg_highest_order = value[2:0];
		else
			cfg_adaptive = value[0];
	endtask

	// wait until nothing is queued, on the bus or in flight
	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_coefs.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// input driver: next item at the falling edge after a transfer
	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_took)) begin
			if (pending_items.size() != 0 &&
				!((idle_mode == 1 && $urandom_range(99) < 54) ||
				  (idle_mode == 3 && $urandom_range(99) < 21))) begin
				in_ch.req_order   <= pending_items[0].order;
				in_ch.step_newest <= pending_items[0].step[0];
				in_ch.step_second <= pending_items[0].step[1];
				in_ch.step_third  <= pending_items[0].step[2];
				in_ch.step_fourth <= pending_items[0].step[3];
				in_ch.valid       <= 1'b1;
				void'(pending_items.pop_front());
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready <= !((idle_mode == 2 && $urandom_range(99) < 54) ||
				(idle_mode == 3 && $urandom_range(99) < 21));
	end

	// input transfer: predict coefficients
	always @(posedge clk) begin
		step_item_t it;
		in_took = in_ch.valid && in_ch.ready;
		if (in_took) begin
			it.order   = in_ch.req_order;
			it.step[0] = in_ch.step_newest;
			it.step[1] = in_ch.step_second;
			it.step[2] = in_ch.step_third;
			it.step[3] = in_ch.step_fourth;
			expected_coefs.push_back(predict_coefs(it));
		end
	end

	// result transfer: compare with oldest prediction
	always @(posedge clk) begin
		coef_set_t want;
		logic [ALPHA_BITS-1:0] got_alpha [4];
		bit bad;
		if (out_ch.valid && out_ch.ready) begin
			got_alpha[0] = out_ch.alpha_one;
			got_alpha[1] = out_ch.alpha_two;
			got_alpha[2] = out_ch.alpha_three;
			got_alpha[3] = out_ch.alpha_four;
			if (expected_coefs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer, status %0d", out_ch.status);
			end else begin
				want = expected_coefs.pop_front();
				bad = (want.gamma !== out_ch.gamma_zero) || (want.status !== out_ch.status);
				for (int k = 0; k < 4; k++)
					if (want.alpha[k] !== got_alpha[k])
						bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: gamma %h/%h a %h %h %h %h / %h %h %h %h st %0d/%0d",
							want.gamma, out_ch.gamma_zero, want.alpha[0], want.alpha[1],
							want.alpha[2], want.alpha[3], got_alpha[0], got_alpha[1],
							got_alpha[2], got_alpha[3], want.status, out_ch.status);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int phase_order [8];
		int phase_adapt [8];
		step_item_t it;
		phase_order = '{4, 4, 2, 0, 7, 1, 3, 4};
		phase_adapt = '{1, 0, 1, 1, 1, 0, 1, 1};
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.req_order = '0;
		in_ch.step_newest = '0; in_ch.step_second = '0;
		in_ch.step_third = '0; in_ch.step_fourth = '0;
		out_ch.ready = 1'b0;
		cfg_highest_order = 3'd4;
		cfg_adaptive = 1'b1;
		idle_mode = 0;
		mismatches = 0;
		quiet_cycles = 0;
		in_took = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, every order, extremes, zero steps, bad orders
		pending_items.push_back(make_item(1, 5, 5, 5, 5));
		pending_items.push_back(make_item(2, 7, 7, 7, 7));
		pending_items.push_back(make_item(3, 3, 3, 3, 3));
		pending_items.push_back(make_item(4, 1, 1, 1, 1));
		pending_items.push_back(make_item(4, 16777215, 16777215, 16777215, 16777215));
		pending_items.push_back(make_item(2, 16777215, 1, 0, 0));
		pending_items.push_back(make_item(3, 16777215, 1, 1, 0));
		pending_items.push_back(make_item(4, 16777215, 1, 1, 1));
		pending_items.push_back(make_item(4, 1, 16777215, 16777215, 16777215));
		pending_items.push_back(make_item(3, 1, 16777215, 1, 16777215));
		pending_items.push_back(make_item(2, 0, 9, 9, 9));
		pending_items.push_back(make_item(3, 4, 4, 0, 4));
		pending_items.push_back(make_item(4, 4, 4, 4, 0));
		pending_items.push_back(make_item(2, 4, 4, 0, 0));
		pending_items.push_back(make_item(1, 0, 0, 0, 0));
		pending_items.push_back(make_item(0, 3, 3, 3, 3));
		pending_items.push_back(make_item(5, 3, 3, 3, 3));
		pending_items.push_back(make_item(7, 16777215, 16777215, 16777215, 16777215));
		pending_items.push_back(make_item(4, 2, 3, 5, 7));
		pending_items.push_back(make_item(3, 1000, 999, 1001, 3));
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			reg_write(REG_HIGHEST_ORDER, DATA_BITS'(phase_order[p]));
			reg_write(REG_ADAPTIVE_MODE, DATA_BITS'(phase_adapt[p]));
			idle_mode = p % 4;
			for (int n = 0; n < 75; n++) begin
				it = random_item();
				pending_items.push_back(it);
				// sender holds off until all results are back
				if (p == 2 && n == 37)
					while (pending_items.size() != 0 || expected_coefs.size() != 0 ||
						in_ch.valid)
						@(posedge clk);
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_coefs.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
